@@ rtl/vrht_pkg.sv @@
// Shared types and constants for the viewshed ray horizon tracker.
package vrht_pkg;

  localparam int RAY_W       = 12;
  localparam int PIX_W       = 16;
  localparam int HEIGHT_W    = 25;
  localparam int DIST_W      = 27;
  localparam int ANGLE_W     = 32;
  localparam int RAY_COUNT_DEF = 4096;

  // Shared divider geometry: numerator covers d*d, c1*c1 and |elev|<<16.
  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam int C1_W   = 24;
  localparam int C2_W   = 16;
  localparam int ELEV_W = 27;

  // Curvature divides by 2R and 6R; both carry a factor of eight, dropped up front.
  localparam int     RECIP_PRE_SH = 3;
  localparam longint EARTH_2R_ODD = 64'sd159453425;
  localparam longint EARTH_6R_ODD = 64'sd478360275;

  // Reciprocals exact for the pre-shifted squares (below 2^51 and 2^45).
  localparam int RECIP_W  = 52;
  localparam int LIMB_W   = 26;
  localparam int C1_SHIFT = 79;
  localparam int C2_SHIFT = 74;
  localparam logic [RECIP_W-1:0] RECIP_2R =
    RECIP_W'(((104'd1 << C1_SHIFT) + 104'(EARTH_2R_ODD) - 104'd1) / 104'(EARTH_2R_ODD));
  localparam logic [RECIP_W-1:0] RECIP_6R =
    RECIP_W'(((104'd1 << C2_SHIFT) + 104'(EARTH_6R_ODD) - 104'd1) / 104'(EARTH_6R_ODD));

  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_RM1, S_MUL2, S_RM2,
    S_ELEV, S_ST3, S_DV3, S_DONE
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/vrht_sample_if.sv @@
// Request and result channel interfaces of the ray horizon tracker.
interface vrht_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic [vrht_pkg::RAY_W-1:0]           ray;
  logic                                 new_ray;
  logic [vrht_pkg::PIX_W-1:0]           pixel_col;
  logic [vrht_pkg::PIX_W-1:0]           pixel_row;
  logic signed [vrht_pkg::HEIGHT_W-1:0] terrain_height;
  logic [vrht_pkg::DIST_W-1:0]          distance;

  modport source (output valid, ray, new_ray, pixel_col, pixel_row, terrain_height, distance,
                  input ready);
  modport sink   (input valid, ray, new_ray, pixel_col, pixel_row, terrain_height, distance,
                  output ready);
endinterface

interface vrht_result_if;
  logic                       valid;
  logic                       ready;
  logic                       visible;
  logic [vrht_pkg::PIX_W-1:0] out_col;
  logic [vrht_pkg::PIX_W-1:0] out_row;

  modport source (output valid, visible, out_col, out_row, input ready);
  modport sink   (input valid, visible, out_col, out_row, output ready);
endinterface

@@ rtl/vrht_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module vrht_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vrht_pkg::div_req_t  req_i,
  output vrht_pkg::div_rsp_t  rsp_o
);
  import vrht_pkg::*;

  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;
  logic [DIV_DEN_W:0]   rem_sub;

  assign rem_sh  = {rem_q, num_q[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      // Shift in the next numerator bit, subtract when it fits.
      num_q <= {num_q[DIV_NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
endmodule

@@ rtl/vrht_mem.sv @@
// Per-ray horizon angle memory, one write and one registered read port.
module vrht_mem #(
  parameter int DEPTH = vrht_pkg::RAY_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [vrht_pkg::ANGLE_W-1:0] wdata_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic signed [vrht_pkg::ANGLE_W-1:0] rdata_o
);
  import vrht_pkg::*;

  logic signed [ANGLE_W-1:0] mem_q [DEPTH];
  logic signed [ANGLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/viewshed_ray_horizon_tracker_core.sv @@
// Ray horizon tracker: one terrain sample in, one visibility verdict out, per-ray max angle.
// After reset the block sweeps the horizon memory, one entry per cycle, before it takes
// the first request; viewer height writes are taken meanwhile.
// For a sample with nonzero distance, two reciprocal multiplications of four partial
// products each give the curvature terms d^2/2R and c1^2/6R, and the elevation angle
// comes from a 54-bit restoring divider at one quotient bit per cycle. A sample at
// distance zero skips the multiplications and the divider. A finished result sits in
// an output register, so the next request is taken while it waits; a second finished
// result stalls until the first is taken.
// The ray index wraps modulo RAY_COUNT.
module viewshed_ray_horizon_tracker_core #(
  parameter int RAY_COUNT = vrht_pkg::RAY_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic signed [vrht_pkg::HEIGHT_W-1:0] cfg_wdata_i,
  vrht_sample_if.sink                          sample_i,
  vrht_result_if.source                        result_o
);
  import vrht_pkg::*;

  localparam int     IDX_W   = $clog2(RAY_COUNT);
  localparam int     MOD_SH  = RAY_W + IDX_W;
  localparam longint MOD_MUL = ((64'sd1 <<< MOD_SH) + longint'(RAY_COUNT) - 64'sd1) /
                               longint'(RAY_COUNT);

  state_e state_q, state_d;

  logic signed [HEIGHT_W-1:0] viewer_q;
  logic [IDX_W-1:0]           clr_q;
  logic [IDX_W-1:0]           slot_q;
  logic                       new_ray_q;
  logic [PIX_W-1:0]           col_q, row_q;
  logic signed [HEIGHT_W-1:0] height_q;
  logic [DIST_W-1:0]          dist_q;
  logic signed [ANGLE_W-1:0]  hz_q;
  logic signed [ANGLE_W-1:0]  angle_q;
  logic [DIV_NUM_W-1:0]       prod_q;
  logic [C1_W-1:0]            c1_q;
  logic [2*RECIP_W-1:0]       acc_q;
  logic [1:0]                 pp_q;
  logic                       neg_q;
  logic                       out_vld_q, vis_q;
  logic [PIX_W-1:0]           out_col_q, out_row_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      mem_we, mem_re;
  logic [IDX_W-1:0]          mem_waddr, in_slot;
  logic signed [ANGLE_W-1:0] mem_wdata, mem_rdata;
  logic                      accept, out_free, vis;
  logic signed [HEIGHT_W:0]  h_diff;
  logic signed [ELEV_W-1:0]  elev;
  logic [ELEV_W-1:0]         elev_mag;
  logic [DIV_NUM_W-1:0]      q;
  logic signed [ANGLE_W-1:0] sat_angle;
  logic [31:0]               mod_prod, mod_quot, mod_slot;
  logic [RECIP_W-1:0]        rm_x, rm_m;
  logic [LIMB_W-1:0]         x_limb, m_limb;
  logic [2*LIMB_W-1:0]       pp;
  logic [2*RECIP_W-1:0]      pp_term;
  logic [C1_W-1:0]           c1_now;
  logic [C2_W-1:0]           c2_now;
  logic [2*DIST_W-1:0]       d_sq;
  logic [2*C1_W-1:0]         c1_sq;

  // Reduce the ray index by reciprocal multiplication.
  assign mod_prod = 32'(sample_i.ray) * 32'(MOD_MUL);
  assign mod_quot = mod_prod >> MOD_SH;
  assign mod_slot = 32'(sample_i.ray) - mod_quot * 32'(RAY_COUNT);
  assign in_slot  = IDX_W'(mod_slot);

  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_vld_q || result_o.ready;
  assign vis      = (dist_q != '0) && (angle_q > hz_q);

  // Curvature quotient: one 26x26 partial product of x*M per cycle.
  assign rm_x    = RECIP_W'(prod_q[DIV_NUM_W-1:RECIP_PRE_SH]);
  assign rm_m    = (state_q == S_RM2) ? RECIP_6R : RECIP_2R;
  assign x_limb  = pp_q[1] ? rm_x[RECIP_W-1:LIMB_W] : rm_x[LIMB_W-1:0];
  assign m_limb  = pp_q[0] ? rm_m[RECIP_W-1:LIMB_W] : rm_m[LIMB_W-1:0];
  assign pp      = x_limb * m_limb;
  assign pp_term = (2*RECIP_W)'(pp) << (LIMB_W * (int'(pp_q[0]) + int'(pp_q[1])));
  assign c1_now  = acc_q[C1_SHIFT +: C1_W];
  assign c2_now  = acc_q[C2_SHIFT +: C2_W];
  assign d_sq    = dist_q * dist_q;
  assign c1_sq   = c1_now * c1_now;

  assign h_diff   = (HEIGHT_W+1)'(height_q) - (HEIGHT_W+1)'(viewer_q);
  assign elev     = ELEV_W'(h_diff) - ELEV_W'(c1_q) + ELEV_W'(c2_now);
  assign elev_mag = elev[ELEV_W-1] ? ELEV_W'(-elev) : ELEV_W'(elev);

  // Saturate the truncated quotient to signed Q15.16.
  assign q = div_rsp.quot;
  always_comb begin
    if (neg_q) begin
      if ((q[DIV_NUM_W-1:ANGLE_W] != '0) || (q[ANGLE_W-1] && (q[ANGLE_W-2:0] != '0)))
        sat_angle = ANGLE_MIN;
      else
        sat_angle = ANGLE_W'(-q[ANGLE_W-1:0]);
    end else begin
      if (q[DIV_NUM_W-1:ANGLE_W-1] != '0) sat_angle = ANGLE_MAX;
      else                                sat_angle = ANGLE_W'(q[ANGLE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d          = state_q;
    sample_i.ready   = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = slot_q;
    mem_wdata        = vis ? angle_q : hz_q;
    mem_re           = 1'b0;
    div_req.start    = 1'b0;
    div_req.num      = prod_q;
    div_req.den      = DIV_DEN_W'(dist_q);
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = ANGLE_MIN;
        if (clr_q == IDX_W'(RAY_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        sample_i.ready = 1'b1;
        mem_re         = 1'b1;
        if (sample_i.valid) state_d = S_LOAD;
      end
      S_LOAD: state_d = (dist_q == '0) ? S_DONE : S_RM1;
      S_RM1:  if (pp_q == 2'd3) state_d = S_MUL2;
      S_MUL2: state_d = S_RM2;
      S_RM2:  if (pp_q == 2'd3) state_d = S_ELEV;
      S_ELEV: state_d = S_ST3;
      S_ST3: begin
        div_req.start = 1'b1;
        state_d       = S_DV3;
      end
      S_DV3:  if (div_rsp.done) state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          mem_we  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_q  <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) viewer_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_DONE && out_free) out_vld_q <= 1'b1;
      else if (result_o.ready)           out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q    <= in_slot;
      new_ray_q <= sample_i.new_ray;
      col_q     <= sample_i.pixel_col;
      row_q     <= sample_i.pixel_row;
      height_q  <= sample_i.terrain_height;
      dist_q    <= sample_i.distance;
    end
    case (state_q)
      S_LOAD: begin
        hz_q    <= new_ray_q ? ANGLE_MIN : mem_rdata;
        angle_q <= ANGLE_MIN;
        prod_q  <= DIV_NUM_W'(d_sq);
        acc_q   <= '0;
        pp_q    <= '0;
      end
      S_RM1, S_RM2: begin
        acc_q <= acc_q + pp_term;
        pp_q  <= pp_q + 1'b1;
      end
      S_MUL2: begin
        c1_q   <= c1_now;
        prod_q <= DIV_NUM_W'(c1_sq);
        acc_q  <= '0;
        pp_q   <= '0;
      end
      S_ELEV: begin
        neg_q  <= elev[ELEV_W-1];
        prod_q <= DIV_NUM_W'({elev_mag, 16'd0});
      end
      S_DV3:  if (div_rsp.done) angle_q <= sat_angle;
      S_DONE: begin
        if (out_free) begin
          vis_q     <= vis;
          out_col_q <= col_q;
          out_row_q <= row_q;
        end
      end
      default: ;
    endcase
  end

  vrht_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vrht_mem #(
    .DEPTH (RAY_COUNT),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (in_slot),
    .rdata_o (mem_rdata)
  );

  assign result_o.valid   = out_vld_q;
  assign result_o.visible = vis_q;
  assign result_o.out_col = out_col_q;
  assign result_o.out_row = out_row_q;
endmodule
